// File: rtl/core/mqes_pkg.sv
package mqes_pkg;

    // Fixed field widths of the block.
    localparam int TIME_W     = 48;
    localparam int DRAW_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int AREA_W     = 64;
    localparam int FRAC_W     = 16;
    localparam int DIVIDEND_W = AREA_W + FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [AREA_W-1:0]  AREA_MAX  = {AREA_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [31:0]        Q_MAX     = 32'hFFFF_FFFF;

    localparam logic [DRAW_W-1:0] COLLECT_RESET = DRAW_W'(100) << FRAC_W;
    localparam logic [TIME_W-1:0] SIM_END_RESET = TIME_W'(100000) << FRAC_W;

    // Configuration register indexes.
    localparam logic [1:0] REG_COLLECT = 2'd0;
    localparam logic [1:0] REG_SIM_END = 2'd1;

    // Event kinds.
    localparam logic [1:0] EV_START   = 2'd0;
    localparam logic [1:0] EV_COLLECT = 2'd1;
    localparam logic [1:0] EV_ARRIVAL = 2'd2;
    localparam logic [1:0] EV_DEPART  = 2'd3;

    // Sequencer states.
    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_DECIDE = 11'b000_0000_0010,
        ST_A_DT   = 11'b000_0000_0100,
        ST_A_LO   = 11'b000_0000_1000,
        ST_A_HI   = 11'b000_0001_0000,
        ST_A_MRG  = 11'b000_0010_0000,
        ST_A_ADD  = 11'b000_0100_0000,
        ST_L_MUL  = 11'b000_1000_0000,
        ST_D_GO   = 11'b001_0000_0000,
        ST_D_WAIT = 11'b010_0000_0000,
        ST_FINISH = 11'b100_0000_0000
    } state_t;

    // Which area accumulator is being updated.
    typedef enum logic [1:0] {
        AR_OCC = 2'd0,
        AR_ARR = 2'd1,
        AR_DEP = 2'd2
    } area_sel_t;

    // Which statistic the divider is working on.
    typedef enum logic [1:0] {
        DV_EN   = 2'd0,
        DV_EW   = 2'd1,
        DV_LEW  = 2'd2,
        DV_UTIL = 2'd3
    } div_step_t;

endpackage

// File: rtl/core/mm1_queue_event_stepper_unit.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   interarrival, service
// out       output     out_valid / out_ready event and statistics fields
// cfg       input      cfg_we                cfg_index, cfg_data
//
// A collection event runs four 80-bit divisions on the shared
// one-bit-per-cycle divider plus three area updates.
// Area products go through one shared 32x32 multiplier, two passes each.
// Reset is asynchronous and clears the counts and area accumulators; the block is idle after it.
// A waiting result holds the sequencer before it writes the next one.
module mm1_queue_event_stepper_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] interarrival,
    input  logic [31:0] service,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [47:0] event_time,
    output logic [31:0] queue_length,
    output logic [31:0] queue_peak,
    output logic [31:0] mean_in_system,
    output logic [31:0] mean_sojourn,
    output logic signed [31:0] little_error,
    output logic [31:0] utilization,
    output logic        stats_valid,
    output logic        run_done,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import mqes_pkg::*;

    state_t    state_reg, state_next;
    area_sel_t sel_reg;
    div_step_t step_reg;

    logic [DRAW_W-1:0]  collect_reg;
    logic [TIME_W-1:0]  sim_end_reg;
    logic [DRAW_W-1:0]  inter_reg, svc_reg;
    logic               started_reg, busy_reg, finished_reg;
    logic [TIME_W-1:0]  nat_reg, ndt_reg, nct_reg, t_reg;
    logic [1:0]         kind_reg;
    logic [COUNT_W-1:0] insys_reg, peak_reg, arr_cnt_reg, dep_cnt_reg;
    logic [AREA_W-1:0]  occ_area_reg, arr_area_reg, dep_area_reg, busy_sum_reg;
    logic [TIME_W-1:0]  occ_last_reg, arr_last_reg, dep_last_reg;
    logic [TIME_W-1:0]  dt_reg;
    logic [AREA_W-1:0]  lo_reg, prod_reg;
    logic [31:0]        en_reg, ew_reg, lew_reg, util_reg;

    logic               out_valid_reg;
    logic [1:0]         o_kind_reg;
    logic [TIME_W-1:0]  o_time_reg;
    logic [31:0]        o_len_reg, o_peak_reg, o_en_reg, o_ew_reg, o_err_reg, o_util_reg;
    logic               o_stats_reg, o_done_reg;

    logic [31:0]           mul_a, mul_b;
    logic [63:0]           mul_p;
    logic                  div_start, div_done;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [TIME_W-1:0]     div_divisor;
    logic [31:0]           div_q;

    logic               in_acc;
    logic               out_free;
    logic [TIME_W-1:0]  last_sel;
    logic [COUNT_W-1:0] cnt_sel;
    logic [AREA_W-1:0]  area_sel;
    logic [79:0]        sum80;
    logic [AREA_W:0]    area_sum;
    logic [AREA_W-1:0]  area_new;
    logic [AREA_W-1:0]  diff;
    logic               coll_first, arr_first;

    assign in_acc   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // Shared units.
    mqes_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    mqes_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Selected area accumulator and its operands.
    always_comb
    begin
        case (sel_reg)
            AR_OCC:
            begin
                last_sel = occ_last_reg;
                cnt_sel  = insys_reg;
                area_sel = occ_area_reg;
            end
            AR_ARR:
            begin
                last_sel = arr_last_reg;
                cnt_sel  = arr_cnt_reg;
                area_sel = arr_area_reg;
            end
            default:
            begin
                last_sel = dep_last_reg;
                cnt_sel  = dep_cnt_reg;
                area_sel = dep_area_reg;
            end
        endcase
        sum80    = {16'b0, lo_reg} + {mul_p[47:0], 32'b0};
        area_sum = {1'b0, area_sel} + {1'b0, prod_reg};
        area_new = area_sum[AREA_W] ? AREA_MAX : area_sum[AREA_W-1:0];
        diff     = (arr_area_reg >= dep_area_reg) ? (arr_area_reg - dep_area_reg) : '0;
    end

    // Event choice: collection beats arrival, arrival beats departure.
    always_comb
    begin
        coll_first = (nct_reg <= nat_reg) && (!busy_reg || nct_reg <= ndt_reg);
        arr_first  = !busy_reg || (nat_reg <= ndt_reg);
    end

    // Multiplier operands.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_A_LO:
            begin
                mul_a = dt_reg[31:0];
                mul_b = cnt_sel;
            end
            ST_A_HI:
            begin
                mul_a = {16'b0, dt_reg[47:32]};
                mul_b = cnt_sel;
            end
            ST_L_MUL:
            begin
                mul_a = arr_cnt_reg;
                mul_b = ew_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider operands.
    always_comb
    begin
        div_start = (state_reg == ST_D_GO);
        case (step_reg)
            DV_EN:
            begin
                div_dividend = {occ_area_reg, {FRAC_W{1'b0}}};
                div_divisor  = t_reg;
            end
            DV_EW:
            begin
                div_dividend = {{FRAC_W{1'b0}}, diff};
                div_divisor  = {16'b0, arr_cnt_reg};
            end
            DV_LEW:
            begin
                div_dividend = {mul_p, {FRAC_W{1'b0}}};
                div_divisor  = t_reg;
            end
            default:
            begin
                div_dividend = {busy_sum_reg, {FRAC_W{1'b0}}};
                div_divisor  = t_reg;
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !finished_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = started_reg ? ST_A_DT : ST_FINISH;
            end
            ST_A_DT:  state_next = ST_A_LO;
            ST_A_LO:  state_next = ST_A_HI;
            ST_A_HI:  state_next = ST_A_MRG;
            ST_A_MRG: state_next = ST_A_ADD;
            ST_A_ADD:
            begin
                if (sel_reg == AR_OCC
                    || (sel_reg == AR_ARR && kind_reg == EV_COLLECT))
                begin
                    state_next = ST_A_DT;
                end
                else if (kind_reg == EV_COLLECT)
                begin
                    state_next = ST_D_GO;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_L_MUL: state_next = ST_D_GO;
            ST_D_GO:  state_next = ST_D_WAIT;
            ST_D_WAIT:
            begin
                if (div_done)
                begin
                    case (step_reg)
                        DV_EN:   state_next = ST_D_GO;
                        DV_EW:   state_next = ST_L_MUL;
                        DV_LEW:  state_next = ST_D_GO;
                        default: state_next = ST_FINISH;
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer state, configuration and queue state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [TIME_W:0]    tsum;
        logic [TIME_W-1:0]  dep_t;
        logic [AREA_W:0]    bsum;
        logic [COUNT_W-1:0] n_new;
        logic               svc_go;

        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= AR_OCC;
            step_reg      <= DV_EN;
            collect_reg   <= COLLECT_RESET;
            sim_end_reg   <= SIM_END_RESET;
            started_reg   <= 1'b0;
            busy_reg      <= 1'b0;
            finished_reg  <= 1'b0;
            nat_reg       <= '0;
            ndt_reg       <= '0;
            nct_reg       <= {16'b0, COLLECT_RESET};
            t_reg         <= '0;
            kind_reg      <= EV_START;
            insys_reg     <= '0;
            peak_reg      <= '0;
            arr_cnt_reg   <= '0;
            dep_cnt_reg   <= '0;
            occ_area_reg  <= '0;
            arr_area_reg  <= '0;
            dep_area_reg  <= '0;
            busy_sum_reg  <= '0;
            occ_last_reg  <= '0;
            arr_last_reg  <= '0;
            dep_last_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // A taken word clears valid unless a new word is written now.
            if (out_valid_reg && out_ready && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            // Configuration writes.
            if (cfg_we)
            begin
                if (cfg_index == REG_COLLECT)
                begin
                    collect_reg <= cfg_data[DRAW_W-1:0];
                end
                else if (cfg_index == REG_SIM_END)
                begin
                    sim_end_reg <= cfg_data;
                end
            end

            case (state_reg)
                ST_DECIDE:
                begin
                    sel_reg  <= AR_OCC;
                    step_reg <= DV_EN;
                    if (!started_reg)
                    begin
                        kind_reg <= EV_START;
                        t_reg    <= '0;
                    end
                    else if (coll_first)
                    begin
                        kind_reg <= EV_COLLECT;
                        t_reg    <= nct_reg;
                    end
                    else if (arr_first)
                    begin
                        kind_reg <= EV_ARRIVAL;
                        t_reg    <= nat_reg;
                    end
                    else
                    begin
                        kind_reg <= EV_DEPART;
                        t_reg    <= ndt_reg;
                    end
                end
                ST_A_ADD:
                begin
                    case (sel_reg)
                        AR_OCC:
                        begin
                            occ_area_reg <= area_new;
                            occ_last_reg <= t_reg;
                            sel_reg      <= (kind_reg == EV_DEPART) ? AR_DEP : AR_ARR;
                        end
                        AR_ARR:
                        begin
                            arr_area_reg <= area_new;
                            arr_last_reg <= t_reg;
                            sel_reg      <= AR_DEP;
                        end
                        default:
                        begin
                            dep_area_reg <= area_new;
                            dep_last_reg <= t_reg;
                        end
                    endcase
                end
                ST_L_MUL:
                begin
                    step_reg <= DV_LEW;
                end
                ST_D_WAIT:
                begin
                    if (div_done)
                    begin
                        case (step_reg)
                            DV_EN:   step_reg <= DV_EW;
                            DV_EW:   step_reg <= DV_EW;
                            DV_LEW:  step_reg <= DV_UTIL;
                            default: step_reg <= DV_UTIL;
                        endcase
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (t_reg > sim_end_reg)
                        begin
                            finished_reg <= 1'b1;
                        end
                        n_new  = insys_reg;
                        svc_go = 1'b0;
                        case (kind_reg)
                            EV_START:
                            begin
                                started_reg <= 1'b1;
                                nct_reg     <= {16'b0, collect_reg};
                                nat_reg     <= {16'b0, inter_reg};
                            end
                            EV_COLLECT:
                            begin
                                tsum = {1'b0, nct_reg} + {17'b0, collect_reg};
                                nct_reg <= tsum[TIME_W] ? TIME_MAX : tsum[TIME_W-1:0];
                            end
                            EV_ARRIVAL:
                            begin
                                svc_go = (insys_reg == '0);
                                n_new  = (insys_reg != COUNT_MAX) ? insys_reg + 1'b1 : insys_reg;
                                if (arr_cnt_reg != COUNT_MAX)
                                begin
                                    arr_cnt_reg <= arr_cnt_reg + 1'b1;
                                end
                                tsum = {1'b0, t_reg} + {17'b0, inter_reg};
                                nat_reg <= tsum[TIME_W] ? TIME_MAX : tsum[TIME_W-1:0];
                            end
                            default:
                            begin
                                n_new  = (insys_reg != '0) ? insys_reg - 1'b1 : insys_reg;
                                svc_go = (n_new != '0);
                                if (dep_cnt_reg != COUNT_MAX)
                                begin
                                    dep_cnt_reg <= dep_cnt_reg + 1'b1;
                                end
                            end
                        endcase
                        insys_reg <= n_new;
                        if (n_new > peak_reg)
                        begin
                            peak_reg <= n_new;
                        end
                        // A new service keeps the server busy; a plain departure frees it.
                        if (svc_go)
                        begin
                            tsum  = {1'b0, t_reg} + {17'b0, svc_reg};
                            dep_t = tsum[TIME_W] ? TIME_MAX : tsum[TIME_W-1:0];
                            bsum  = {1'b0, busy_sum_reg} + {17'b0, dep_t - t_reg};
                            ndt_reg      <= dep_t;
                            busy_reg     <= 1'b1;
                            busy_sum_reg <= bsum[AREA_W] ? AREA_MAX : bsum[AREA_W-1:0];
                        end
                        else if (kind_reg == EV_DEPART)
                        begin
                            busy_reg <= 1'b0;
                        end
                        o_len_reg  <= n_new;
                        o_peak_reg <= (n_new > peak_reg) ? n_new : peak_reg;
                    end
                end
                default:
                begin
                    sel_reg <= sel_reg;
                end
            endcase
        end
    end

    // Payload registers: captured item, area arithmetic, quotients and result word.
    always_ff @(posedge clk)
    begin
        logic signed [32:0] err;

        if (in_acc)
        begin
            inter_reg <= interarrival;
            svc_reg   <= service;
        end
        if (state_reg == ST_A_DT)
        begin
            dt_reg <= (t_reg >= last_sel) ? t_reg - last_sel : '0;
        end
        if (state_reg == ST_A_HI)
        begin
            lo_reg <= mul_p;
        end
        if (state_reg == ST_A_MRG)
        begin
            prod_reg <= (sum80[79:64] != '0) ? AREA_MAX : sum80[63:0];
        end
        if (state_reg == ST_D_WAIT && div_done)
        begin
            case (step_reg)
                DV_EN:   en_reg   <= div_q;
                DV_EW:   ew_reg   <= div_q;
                DV_LEW:  lew_reg  <= div_q;
                default: util_reg <= div_q;
            endcase
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            err = $signed({1'b0, en_reg}) - $signed({1'b0, lew_reg});
            o_kind_reg  <= kind_reg;
            o_time_reg  <= t_reg;
            o_done_reg  <= (t_reg > sim_end_reg);
            o_stats_reg <= (kind_reg == EV_COLLECT);
            if (kind_reg == EV_COLLECT)
            begin
                o_en_reg   <= en_reg;
                o_ew_reg   <= ew_reg;
                o_util_reg <= util_reg;
                if (err > 33'sh0_7FFF_FFFF)
                begin
                    o_err_reg <= 32'h7FFF_FFFF;
                end
                else if (err < -33'sh0_8000_0000)
                begin
                    o_err_reg <= 32'h8000_0000;
                end
                else
                begin
                    o_err_reg <= err[31:0];
                end
            end
            else
            begin
                o_en_reg   <= '0;
                o_ew_reg   <= '0;
                o_util_reg <= '0;
                o_err_reg  <= '0;
            end
        end
    end

    // Result word.
    assign out_valid      = out_valid_reg;
    assign event_kind     = o_kind_reg;
    assign event_time     = o_time_reg;
    assign queue_length   = o_len_reg;
    assign queue_peak     = o_peak_reg;
    assign mean_in_system = o_en_reg;
    assign mean_sojourn   = o_ew_reg;
    assign little_error   = o_err_reg;
    assign utilization    = o_util_reg;
    assign stats_valid    = o_stats_reg;
    assign run_done       = o_done_reg;

endmodule

// File: rtl/core/mqes_mul.sv
module mqes_mul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);
    import mqes_pkg::*;

    logic [63:0] p_reg;

    // Registered 32x32 product, available in the cycle after the operands.
    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

// File: rtl/core/mqes_div.sv
module mqes_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [mqes_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [mqes_pkg::TIME_W-1:0]     divisor,
    output logic                            done,
    output logic [31:0]                     quotient
);
    import mqes_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [TIME_W-1:0]     d_reg;
    logic [TIME_W-1:0]     r_reg;
    logic [32:0]           q_reg;
    logic                  sticky_reg;
    logic [31:0]           quot_reg;

    logic [TIME_W:0]       r_sh;
    logic                  ge;
    logic [TIME_W:0]       r_sub;
    logic [TIME_W-1:0]     r_next;
    logic [32:0]           q_next;
    logic                  sticky_next;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        r_sh        = {r_reg, dvd_reg[DIVIDEND_W-1]};
        ge          = r_sh >= {1'b0, d_reg};
        r_sub       = r_sh - {1'b0, d_reg};
        r_next      = ge ? r_sub[TIME_W-1:0] : r_sh[TIME_W-1:0];
        q_next      = {q_reg[31:0], ge};
        sticky_next = sticky_reg | q_reg[32];
    end

    // Control: busy flag, bit counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (divisor == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= DIV_CNT_W'(DIVIDEND_W - 1);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Data path of the divider.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg    <= dividend;
            d_reg      <= divisor;
            r_reg      <= '0;
            q_reg      <= '0;
            sticky_reg <= 1'b0;
            quot_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg    <= dvd_reg << 1;
            r_reg      <= r_next;
            q_reg      <= q_next;
            sticky_reg <= sticky_next;
            if (cnt_reg == '0)
            begin
                quot_reg <= (sticky_next | q_next[32]) ? Q_MAX : q_next[31:0];
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
